### hdl/error_diffusion_dither_macros.svh
// assertion macros for the error diffusion dither
`ifndef ERROR_DIFFUSION_DITHER_MACROS_SVH
`define ERROR_DIFFUSION_DITHER_MACROS_SVH

`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define EDD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("edd assertion failed");
// condition in one cycle implies a result in the next
`define EDD_ASSERT_NEXT(lbl, clk, rstn, cond, res) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (res)) \
        else $error("edd assertion failed");
`else
`define EDD_ASSERT(lbl, clk, rstn, prop)
`define EDD_ASSERT_NEXT(lbl, clk, rstn, cond, res)
`endif

`endif

### hdl/edd_pkg.sv
package edd_pkg;

    localparam int MAX_LINE_WIDTH_DEF = 1024;

    localparam int GRAY_W     = 8;
    localparam int LW_W       = 11;
    localparam int WT_W       = 4;
    localparam int ACC_W      = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [LW_W-1:0]   LINE_WIDTH_RST = 11'd640;
    localparam logic [GRAY_W-1:0] THRESHOLD_RST  = 8'h80;
    localparam logic [WT_W-1:0]   W_RIGHT_RST    = 4'd6;
    localparam logic [WT_W-1:0]   W_BLEFT_RST    = 4'd3;
    localparam logic [WT_W-1:0]   W_BELOW_RST    = 4'd5;
    localparam logic [WT_W-1:0]   W_BRIGHT_RST   = 4'd2;

    localparam logic [GRAY_W-1:0] GRAY_FULL = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_WIDTH,
        CFG_THRESHOLD,
        CFG_W_RIGHT,
        CFG_W_BELOW_LEFT,
        CFG_W_BELOW,
        CFG_W_BELOW_RIGHT
    } t_cfg_idx;

    typedef logic signed [ACC_W-1:0] t_acc;

    typedef struct packed {
        logic [GRAY_W-1:0] gray;
        logic              frame_start;
    } t_in_item;

    typedef struct packed {
        logic white;
        logic line_end;
    } t_out_item;

    typedef struct packed {
        logic [WT_W-1:0] right;
        logic [WT_W-1:0] below_left;
        logic [WT_W-1:0] below;
        logic [WT_W-1:0] below_right;
    } t_weights;

    // a: entry left of the current column, b: the current column
    typedef struct packed {
        logic a_en;
        logic b_en;
        t_acc a_data;
        t_acc b_data;
    } t_store_wr;

    function automatic logic signed [ACC_W+1:0] ext_acc(input t_acc v);
        ext_acc = {{2{v[ACC_W-1]}}, v};
    endfunction

    function automatic t_acc sat_acc(input logic signed [ACC_W+1:0] v);
        logic signed [ACC_W+1:0] hi;
        logic signed [ACC_W+1:0] lo;
        hi = (ACC_W+2)'(8191);
        lo = -(ACC_W+2)'(8192);
        if (v > hi) begin
            sat_acc = t_acc'(hi[ACC_W-1:0]);
        end else if (v < lo) begin
            sat_acc = t_acc'(lo[ACC_W-1:0]);
        end else begin
            sat_acc = v[ACC_W-1:0];
        end
    endfunction

endpackage

### hdl/error_diffusion_dither.sv
// channel  direction  handshake              payload
// in       input      i_in_valid/o_in_stall  i_in_item   (gray, frame_start)
// out      output     o_out_valid/i_out_stall o_out_item (white, line_end)
// cfg      input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// one item per clock sustained while the output is not stalled; an item's
// result reaches the output register through stage one (line store read at the
// accepting edge, then quantize and diffuse into the output register). the loop
// through the right carry sets the rate.
// synchronous active-low reset clears control and error registers; the line
// store is not cleared, the first row after a frame start never reads it.
// output stall holds the output register and backs up through stage one.
`include "error_diffusion_dither_macros.svh"

module error_diffusion_dither #(
    parameter int MAX_LINE_WIDTH = edd_pkg::MAX_LINE_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  edd_pkg::t_in_item                   i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output edd_pkg::t_out_item                  o_out_item,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [edd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [edd_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int CW   = $clog2(MAX_LINE_WIDTH);
    // compare width holds both the column plus one and the line width register
    localparam int CMPW = (CW + 1 > edd_pkg::LW_W) ? CW + 1 : edd_pkg::LW_W;

    // configuration registers
    logic [edd_pkg::LW_W-1:0]   r_line_width;
    logic [edd_pkg::GRAY_W-1:0] r_threshold;
    edd_pkg::t_weights          r_wts;

    // position tracking, advanced as each item is accepted
    logic [CW-1:0] r_col;
    logic          r_first_row;

    // stage one: item waiting on its line store read
    logic              r_s1_valid;
    edd_pkg::t_in_item r_s1_item;
    logic [CW-1:0]     r_s1_col;
    logic              r_s1_first;
    logic              r_s1_end;
    logic              r_fwd_hit;
    edd_pkg::t_acc     r_fwd_val;

    // output register
    logic               r_out_valid;
    edd_pkg::t_out_item r_out_item;

    logic               in_acc;
    logic               s1_fire;
    logic [CW-1:0]      cur_col;
    logic               cur_first;
    logic               cur_end;
    logic               n_fwd_hit;
    edd_pkg::t_acc      n_fwd_val;
    edd_pkg::t_acc      rd_data;
    edd_pkg::t_acc      store_val;
    logic               s1_white;
    edd_pkg::t_store_wr wr;

    // handshakes: stage one frees when the output register can take its result
    assign s1_fire    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_fire;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // column of the incoming item; a frame start puts it back at the left edge
    always_comb begin
        cur_col   = i_in_item.frame_start ? '0 : r_col;
        cur_first = i_in_item.frame_start || r_first_row;
        // zero width acts as one, widths above the store act as its size
        cur_end   = (CMPW'(cur_col) + CMPW'(1) >= CMPW'(r_line_width))
                 || (cur_col == CW'(MAX_LINE_WIDTH - 1));
    end

    // the item leaving stage one may write the entry the new item is reading
    always_comb begin
        n_fwd_hit = 1'b0;
        n_fwd_val = wr.b_data;
        if (wr.b_en && (cur_col == r_s1_col)) begin
            n_fwd_hit = 1'b1;
            n_fwd_val = wr.b_data;
        end else if (wr.a_en && (cur_col == r_s1_col - CW'(1))) begin
            n_fwd_hit = 1'b1;
            n_fwd_val = wr.a_data;
        end
    end

    assign store_val = r_fwd_hit ? r_fwd_val : rd_data;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width      <= edd_pkg::LINE_WIDTH_RST;
            r_threshold       <= edd_pkg::THRESHOLD_RST;
            r_wts.right       <= edd_pkg::W_RIGHT_RST;
            r_wts.below_left  <= edd_pkg::W_BLEFT_RST;
            r_wts.below       <= edd_pkg::W_BELOW_RST;
            r_wts.below_right <= edd_pkg::W_BRIGHT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (edd_pkg::t_cfg_idx'(i_cfg_index))
                edd_pkg::CFG_LINE_WIDTH: begin
                    r_line_width <= i_cfg_data;
                end
                edd_pkg::CFG_THRESHOLD: begin
                    r_threshold <= i_cfg_data[edd_pkg::GRAY_W-1:0];
                end
                edd_pkg::CFG_W_RIGHT: begin
                    r_wts.right <= i_cfg_data[edd_pkg::WT_W-1:0];
                end
                edd_pkg::CFG_W_BELOW_LEFT: begin
                    r_wts.below_left <= i_cfg_data[edd_pkg::WT_W-1:0];
                end
                edd_pkg::CFG_W_BELOW: begin
                    r_wts.below <= i_cfg_data[edd_pkg::WT_W-1:0];
                end
                edd_pkg::CFG_W_BELOW_RIGHT: begin
                    r_wts.below_right <= i_cfg_data[edd_pkg::WT_W-1:0];
                end
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    // position and stage one control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_first_row <= 1'b1;
            r_s1_valid  <= 1'b0;
        end else begin
            if (in_acc) begin
                r_col       <= cur_end ? '0 : cur_col + CW'(1);
                r_first_row <= cur_end ? 1'b0 : cur_first;
                r_s1_valid  <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid  <= 1'b0;
            end
        end
    end

    // stage one payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_item  <= i_in_item;
            r_s1_col   <= cur_col;
            r_s1_first <= cur_first;
            r_s1_end   <= cur_end;
            r_fwd_hit  <= n_fwd_hit;
            r_fwd_val  <= n_fwd_val;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_item.white    <= s1_white;
            r_out_item.line_end <= r_s1_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // line store: read as an item is accepted, written as stage one retires
    edd_line_store #(
        .MAX_LINE_WIDTH(MAX_LINE_WIDTH)
    ) u_store (
        .i_clk    (i_clk),
        .i_rd_en  (in_acc),
        .i_rd_col (cur_col),
        .o_rd_data(rd_data),
        .i_wr     (wr),
        .i_wr_col (r_s1_col)
    );

    // quantizer and error spreading for the item in stage one
    edd_diffuse u_diffuse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (s1_fire),
        .i_item     (r_s1_item),
        .i_first_row(r_s1_first),
        .i_line_end (r_s1_end),
        .i_col_nz   (r_s1_col != '0),
        .i_store    (store_val),
        .i_threshold(r_threshold),
        .i_wts      (r_wts),
        .o_white    (s1_white),
        .o_wr       (wr)
    );

    // an accepted item behind a full stage one always moves it along
    `EDD_ASSERT(a_stage_moves, i_clk, i_rst_n, in_acc && r_s1_valid |-> s1_fire)
    // the column never runs past the line store
    `EDD_ASSERT(a_col_range, i_clk, i_rst_n, r_col <= CW'(MAX_LINE_WIDTH - 1))
    // the last item of a line wraps the column and leaves the first row
    `EDD_ASSERT_NEXT(a_line_wrap, i_clk, i_rst_n, in_acc && cur_end, r_col == '0 && !r_first_row)
    // a held result blocks stage one
    `EDD_ASSERT(a_out_hold, i_clk, i_rst_n, r_out_valid && i_out_stall |-> !s1_fire)

endmodule

### hdl/edd_line_store.sv
// next-line error store, split into even and odd column banks
module edd_line_store #(
    parameter int MAX_LINE_WIDTH = edd_pkg::MAX_LINE_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rd_en,
    input  logic [$clog2(MAX_LINE_WIDTH)-1:0] i_rd_col,
    output edd_pkg::t_acc                     o_rd_data,
    input  edd_pkg::t_store_wr                i_wr,
    input  logic [$clog2(MAX_LINE_WIDTH)-1:0] i_wr_col
);

    localparam int CW         = $clog2(MAX_LINE_WIDTH);
    localparam int BANK_AW    = CW - 1;
    localparam int BANK_DEPTH = (MAX_LINE_WIDTH + 1) / 2;

    edd_pkg::t_acc r_even [BANK_DEPTH];
    edd_pkg::t_acc r_odd  [BANK_DEPTH];

    edd_pkg::t_acc r_rd_even;
    edd_pkg::t_acc r_rd_odd;
    logic          r_rd_par;

    logic [BANK_AW-1:0] wr_half;
    logic               even_we;
    logic               odd_we;
    logic [BANK_AW-1:0] odd_addr;
    edd_pkg::t_acc      even_data;
    edd_pkg::t_acc      odd_data;

    // left entry and current entry always fall in opposite banks
    always_comb begin
        wr_half = i_wr_col[CW-1:1];
        if (i_wr_col[0]) begin
            even_we   = i_wr.a_en;
            even_data = i_wr.a_data;
            odd_we    = i_wr.b_en;
            odd_data  = i_wr.b_data;
            odd_addr  = wr_half;
        end else begin
            even_we   = i_wr.b_en;
            even_data = i_wr.b_data;
            odd_we    = i_wr.a_en;
            odd_data  = i_wr.a_data;
            odd_addr  = wr_half - BANK_AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (even_we) begin
            r_even[wr_half] <= even_data;
        end
        if (odd_we) begin
            r_odd[odd_addr] <= odd_data;
        end
        if (i_rd_en) begin
            r_rd_even <= r_even[i_rd_col[CW-1:1]];
            r_rd_odd  <= r_odd[i_rd_col[CW-1:1]];
            r_rd_par  <= i_rd_col[0];
        end
    end

    assign o_rd_data = r_rd_par ? r_rd_odd : r_rd_even;

endmodule

### hdl/edd_diffuse.sv
// quantize one pixel and spread its error to the neighbours
module edd_diffuse (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  edd_pkg::t_in_item             i_item,
    input  logic                          i_first_row,
    input  logic                          i_line_end,
    input  logic                          i_col_nz,
    input  edd_pkg::t_acc                 i_store,
    input  logic [edd_pkg::GRAY_W-1:0]    i_threshold,
    input  edd_pkg::t_weights             i_wts,
    output logic                          o_white,
    output edd_pkg::t_store_wr            o_wr
);

    edd_pkg::t_acc r_carry;
    edd_pkg::t_acc r_pend_a;
    edd_pkg::t_acc r_pend_b;
    edd_pkg::t_acc n_carry;
    edd_pkg::t_acc n_pend_a;
    edd_pkg::t_acc n_pend_b;

    edd_pkg::t_acc carry_in;
    edd_pkg::t_acc pend_a_in;
    edd_pkg::t_acc pend_b_in;
    edd_pkg::t_acc acc;
    logic signed [10:0] corr;
    logic [edd_pkg::GRAY_W-1:0] corr_c;
    logic signed [8:0] err;
    edd_pkg::t_acc p_right;
    edd_pkg::t_acc p_bleft;
    edd_pkg::t_acc p_below;
    edd_pkg::t_acc p_bright;
    edd_pkg::t_acc below_sum;

    always_comb begin
        carry_in  = i_item.frame_start ? '0 : r_carry;
        pend_a_in = i_item.frame_start ? '0 : r_pend_a;
        pend_b_in = i_item.frame_start ? '0 : r_pend_b;

        acc = i_first_row ? carry_in
            : edd_pkg::sat_acc(edd_pkg::ext_acc(carry_in) + edd_pkg::ext_acc(i_store));

        // floor of acc / 16 is an arithmetic shift
        corr = $signed({3'b000, i_item.gray}) + $signed({acc[13], acc[13:4]});
        if (corr[10]) begin
            corr_c = '0;
        end else if (|corr[9:8]) begin
            corr_c = edd_pkg::GRAY_FULL;
        end else begin
            corr_c = corr[7:0];
        end

        o_white = corr_c >= i_threshold;
        err = o_white ? $signed({1'b0, corr_c}) - $signed({1'b0, edd_pkg::GRAY_FULL})
                      : $signed({1'b0, corr_c});

        p_right  = edd_pkg::t_acc'(err) * edd_pkg::t_acc'({1'b0, i_wts.right});
        p_bleft  = edd_pkg::t_acc'(err) * edd_pkg::t_acc'({1'b0, i_wts.below_left});
        p_below  = edd_pkg::t_acc'(err) * edd_pkg::t_acc'({1'b0, i_wts.below});
        p_bright = edd_pkg::t_acc'(err) * edd_pkg::t_acc'({1'b0, i_wts.below_right});

        below_sum = edd_pkg::sat_acc(edd_pkg::ext_acc(pend_b_in) + edd_pkg::ext_acc(p_below));

        o_wr.a_en   = i_fire && i_col_nz;
        o_wr.a_data = edd_pkg::sat_acc(edd_pkg::ext_acc(pend_a_in) + edd_pkg::ext_acc(p_bleft));
        o_wr.b_en   = i_fire && i_line_end;
        o_wr.b_data = below_sum;

        if (i_line_end) begin
            n_carry  = '0;
            n_pend_a = '0;
            n_pend_b = '0;
        end else begin
            n_carry  = p_right;
            n_pend_a = below_sum;
            n_pend_b = p_bright;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry  <= '0;
            r_pend_a <= '0;
            r_pend_b <= '0;
        end else if (i_fire) begin
            r_carry  <= n_carry;
            r_pend_a <= n_pend_a;
            r_pend_b <= n_pend_b;
        end
    end

endmodule
